@@ rtl/bcd_pkg.sv @@
package bcd_pkg;

  localparam int NUM_BUTTONS = 10;
  localparam int SLOT_W      = 4;
  localparam int KIND_W      = 2;
  localparam int TIME_W      = 32;
  localparam int THR_W       = 16;
  localparam int MASK_W      = 10;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam logic [THR_W-1:0] THR_RESET = 16'd250;

  // event kind codes
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;

  // one access to the press-time memory
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [TIME_W-1:0] wdata;
  } mem_req_t;

endpackage

@@ rtl/bcd_if.sv @@
interface bcd_in_if;
  import bcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] button_slot;
  logic [KIND_W-1:0] event_kind;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, button_slot, event_kind, time_ms, input ready);
  modport sink   (input valid, button_slot, event_kind, time_ms, output ready);
endinterface

interface bcd_out_if;
  import bcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] hold_mask;
  logic [SLOT_W-1:0] tap_button;

  modport source (output valid, hold_mask, tap_button, input ready);
  modport sink   (input valid, hold_mask, tap_button, output ready);
endinterface

@@ rtl/bcd_time_mem.sv @@
module bcd_time_mem
  import bcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_req_t          req,
  output logic [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0]      mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] written_r;
  logic [TIME_W-1:0]      q_r;
  logic                   hit_r;

  // written bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (req.we) begin
      written_r[req.addr] <= 1'b1;
    end
  end

  // storage array, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      q_r   <= mem[req.addr];
      hit_r <= written_r[req.addr];
    end
  end

  assign rdata = hit_r ? q_r : '0;

endmodule

@@ rtl/bcd_seq.sv @@
module bcd_seq
  import bcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bcd_in_if.sink            in_if,
  bcd_out_if.source         out_if,
  input  logic [THR_W-1:0]  thr,
  output mem_req_t          mem_req,
  input  logic [TIME_W-1:0] mem_rdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_TAP, ST_SCAN, ST_HOLD} state_t;

  state_t                 state_r, state_nxt;
  logic [NUM_BUTTONS-1:0] flags_r, flags_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [TIME_W-1:0]      tap_time_r, tap_time_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [MASK_W-1:0]      acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]      out_mask_r, out_mask_nxt;
  logic [SLOT_W-1:0]      out_tap_r, out_tap_nxt;

  logic              slot_ok;
  logic [IDX_W-1:0]  in_idx;
  logic signed [TIME_W:0] thr_s;
  logic signed [TIME_W:0] diff_s;
  logic              is_tap;
  logic              is_hold;
  logic              out_free;
  logic [MASK_W-1:0] acc_scan;

  assign slot_ok  = {1'b0, in_if.button_slot} < (SLOT_W+1)'(NUM_BUTTONS);
  assign in_idx   = in_if.button_slot[IDX_W-1:0];
  assign thr_s    = $signed({{(TIME_W+1-THR_W){1'b0}}, thr});
  // signed 33-bit age of the entry just read
  assign diff_s   = $signed({1'b0, now_r}) - $signed({1'b0, mem_rdata});
  assign is_tap   = diff_s < thr_s;
  assign is_hold  = flags_r[idx_r] && (diff_s > thr_s) && (tap_time_r > mem_rdata);
  assign out_free = !out_valid_r || out_if.ready;

  // accumulated mask including the entry under scan
  always_comb begin
    acc_scan = acc_r;
    for (int j = 0; j < MASK_W; j++) begin
      if (is_hold && (32'(idx_r) == j)) begin
        acc_scan[j] = 1'b1;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    now_nxt       = now_r;
    tap_time_nxt  = tap_time_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_mask_nxt  = out_mask_r;
    out_tap_nxt   = out_tap_r;
    mem_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid && slot_ok) begin
          if (in_if.event_kind == KIND_PRESS) begin
            flags_nxt[in_idx] = 1'b1;
            mem_req.we        = 1'b1;
            mem_req.addr      = in_idx;
            mem_req.wdata     = in_if.time_ms;
          end else if (in_if.event_kind == KIND_RELEASE) begin
            flags_nxt[in_idx] = 1'b0;
            mem_req.re        = 1'b1;
            mem_req.addr      = in_idx;
            now_nxt           = in_if.time_ms;
            slot_nxt          = in_if.button_slot;
            state_nxt         = ST_TAP;
          end
        end
      end
      ST_TAP: begin
        // released button's press time is on the read port
        if (is_tap) begin
          tap_time_nxt = mem_rdata;
          acc_nxt      = '0;
          idx_nxt      = '0;
          mem_req.re   = 1'b1;
          mem_req.addr = '0;
          state_nxt    = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        acc_nxt = acc_scan;
        if (idx_r == IDX_W'(NUM_BUTTONS - 1)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_mask_nxt  = acc_scan;
            out_tap_nxt   = slot_r;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          idx_nxt      = IDX_W'(idx_r + 1'b1);
          mem_req.re   = 1'b1;
          mem_req.addr = IDX_W'(idx_r + 1'b1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = acc_r;
          out_tap_nxt   = slot_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r      <= now_nxt;
    tap_time_r <= tap_time_nxt;
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    out_mask_r <= out_mask_nxt;
    out_tap_r  <= out_tap_nxt;
  end

  assign in_if.ready       = (state_r == ST_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.hold_mask  = out_mask_r;
  assign out_if.tap_button = out_tap_r;

  // checks
  logic tap_in_mask;
  logic [MASK_W-1:0] flags_vis;
  always_comb begin
    flags_vis = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (j < NUM_BUTTONS) begin
        flags_vis[j] = flags_r[j];
      end
    end
  end
  assign tap_in_mask = |(out_mask_r & (MASK_W'(1) << out_tap_r));

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> !mem_req.re)
    else $error("memory read and write in the same cycle");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(idx_r) < NUM_BUTTONS))
    else $error("scan index past last button");

  a_tap_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !tap_in_mask)
    else $error("released button appears in its own hold mask");

  a_mask_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_IDLE) && (state_nxt == ST_IDLE) && out_valid_nxt && !out_valid_r)
      |=> ((out_mask_r & ~flags_vis) == '0))
    else $error("hold mask names a button that is not pressed");

endmodule

@@ rtl/button_chord_detector.sv @@
// Button chord detector. Takes timestamped press/release events and, when a
// button is released within hold_threshold_ms of its press, emits one item
// with the slot of that button and a mask of the buttons being held under it
// (still pressed, pressed earlier, and down longer than the threshold). Press
// times sit in a small single-port memory; pressed flags are flip-flops.
// A press, repeat or ignored slot is taken in the idle state, a long release
// goes on to the tap check, and a tap release then scans every button, one
// press time per cycle through the memory's one read port. A result
// waits in an output register while the next item is taken. cfg_we writes
// the threshold (reset 250 ms); write it only while the block is idle.
module button_chord_detector
  import bcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  bcd_in_if.sink           in_if,
  bcd_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  logic [THR_W-1:0]  thr_r;
  mem_req_t          mem_req;
  logic [TIME_W-1:0] mem_rdata;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  bcd_time_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  bcd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .thr       (thr_r),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

@@ dv/tb_button_chord_detector.sv @@
module tb_button_chord_detector
  import bcd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // event kinds the block ignores
  localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = NUM_BUTTONS + 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 2000;
  localparam int N_PHASES        = 7;
  localparam int PHASE_EVENTS    = 225;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] stamp;
  } button_event_t;

  typedef struct packed {
    logic [MASK_W-1:0] hold_mask;
    logic [SLOT_W-1:0] tap_button;
  } chord_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  bcd_in_if  in_ch ();
  bcd_out_if out_ch ();

  button_chord_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block's button state
  logic             held_down   [NUM_BUTTONS];
  logic [TIME_W-1:0] press_stamp [NUM_BUTTONS];
  logic [THR_W-1:0] hold_limit;

  button_event_t event_backlog [$];
  chord_t        pending_chords [$];

  int items_total;
  int items_sent;
  int live_events;
  int chords_checked;
  int mismatch_count;
  int settings_used;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_asked;
  int hold_off_granted;
  int hold_off_left;
  logic in_took;
  logic [TIME_W-1:0] stamp_clock;
  button_event_t drive_ev;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("chord mismatch: %s got %0d expected %0d (chord %0d)",
             what, got, want, chords_checked);
    mismatch_count++;
  endtask

  // update the shadow state with one accepted event, queue any chord it yields
  function automatic void track_button_event(input button_event_t ev);
    longint now_ms;
    longint tap_ms;
    longint limit_ms;
    longint held_ms;
    logic [TIME_W-1:0] tap_press;
    chord_t res;
    if (ev.slot >= NUM_BUTTONS) return;
    if (ev.kind == KIND_PRESS) begin
      held_down[ev.slot]   = 1'b1;
      press_stamp[ev.slot] = ev.stamp;
      return;
    end
    if (ev.kind != KIND_RELEASE) return;
    held_down[ev.slot] = 1'b0;
    tap_press = press_stamp[ev.slot];
    now_ms    = ev.stamp;
    tap_ms    = tap_press;
    limit_ms  = hold_limit;
    if (!(now_ms - tap_ms < limit_ms)) return;
    res.hold_mask  = '0;
    res.tap_button = ev.slot;
    for (int i = 0; i < NUM_BUTTONS && i < MASK_W; i++) begin
      held_ms = press_stamp[i];
      if (held_down[i] && (now_ms - held_ms > limit_ms) && (tap_press > press_stamp[i]))
        res.hold_mask[i] = 1'b1;
    end
    pending_chords.push_back(res);
  endfunction

  // input driver: next item from the backlog, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (event_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_ev = event_backlog.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.button_slot <= drive_ev.slot;
        in_ch.event_kind  <= drive_ev.kind;
        in_ch.time_ms     <= drive_ev.stamp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_ch.ready  <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_granted != hold_off_asked) begin
      out_ch.ready     <= 1'b0;
      hold_off_granted <= hold_off_granted + 1;
      hold_off_left    <= HOLD_OFF_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: check chords, predict from accepted events, watchdog
  always @(posedge clk) begin
    chord_t got;
    chord_t want;
    if (rst_n) begin
      if (cfg_we) hold_limit = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.hold_mask  = out_ch.hold_mask;
        got.tap_button = out_ch.tap_button;
        chords_checked++;
        if (pending_chords.size() == 0) begin
          flag_mismatch("unexpected chord, tap_button", got.tap_button, -1);
        end else begin
          want = pending_chords.pop_front();
          if (got.hold_mask !== want.hold_mask)
            flag_mismatch("hold_mask", got.hold_mask, want.hold_mask);
          if (got.tap_button !== want.tap_button)
            flag_mismatch("tap_button", got.tap_button, want.tap_button);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        track_button_event('{in_ch.button_slot, in_ch.event_kind, in_ch.time_ms});
        items_sent <= items_sent + 1;
      end
      in_took <= in_ch.valid && in_ch.ready;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", quiet_cycles);
        $display("button_chord_detector regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_event(input logic [SLOT_W-1:0] slot, input logic [KIND_W-1:0] kind,
                             input logic [TIME_W-1:0] stamp);
    event_backlog.push_back('{slot, kind, stamp});
    items_total++;
    if (slot < NUM_BUTTONS && (kind == KIND_PRESS || kind == KIND_RELEASE))
      live_events++;
  endtask

  // holds pressed, then a tap pressed and released near the threshold
  task automatic queue_chord_burst(input int thr);
    int n_holds;
    int pick;
    logic [SLOT_W-1:0] holds [4];
    logic [SLOT_W-1:0] tap_slot;
    logic [TIME_W-1:0] tap_press;
    logic [TIME_W-1:0] release_at;
    n_holds = $urandom_range(0, 3);
    for (int i = 0; i < n_holds; i++) begin
      holds[i] = SLOT_W'($urandom_range(0, NUM_BUTTONS - 1));
      queue_event(holds[i], KIND_PRESS, stamp_clock);
      stamp_clock += $urandom_range(0, thr / 4 + 3);
    end
    stamp_clock += $urandom_range(thr / 2, thr + thr / 2 + 2);
    tap_slot  = SLOT_W'($urandom_range(0, NUM_BUTTONS - 1));
    tap_press = stamp_clock;
    queue_event(tap_slot, KIND_PRESS, tap_press);
    if ($urandom_range(0, 3) == 0) queue_event(tap_slot, KIND_REPEAT, tap_press);
    // release exactly at the threshold, before the press, or inside the tap window
    pick = $urandom_range(0, 9);
    if (pick == 0)
      release_at = tap_press + thr;
    else if (pick == 1 || (thr == 0 && pick < 6))
      release_at = tap_press - $urandom_range(1, 100);
    else
      release_at = tap_press + $urandom_range(0, (thr > 0) ? thr - 1 : 0);
    queue_event(tap_slot, KIND_RELEASE, release_at);
    if (release_at > stamp_clock) stamp_clock = release_at;
    stamp_clock += $urandom_range(0, 20);
    for (int i = 0; i < n_holds; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        queue_event(holds[i], KIND_RELEASE, stamp_clock);
        stamp_clock += $urandom_range(0, 10);
      end
    end
  endtask

  // any slot, any kind, sometimes a jump in time
  task automatic queue_noise();
    case ($urandom_range(0, 3))
      0: stamp_clock = $urandom();
      1: stamp_clock += $urandom_range(0, 300);
      default: ;
    endcase
    queue_event(SLOT_W'($urandom_range(0, 15)), KIND_W'($urandom_range(0, 3)), stamp_clock);
  endtask

  // all items in, all chords out, then let a tap scan finish
  task automatic wait_drained();
    do @(negedge clk);
    while (!(items_sent == items_total && pending_chords.size() == 0));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // stimulus
  initial begin
    int phase_thr [N_PHASES];
    int phase_send [N_PHASES];
    int phase_stall [N_PHASES];
    int thr;
    int target;
    phase_thr   = '{1000, 250, 0, 65535, -1, 1, 500};
    phase_send  = '{0, 0, 45, 0, 8, 0, 45};
    phase_stall = '{0, 0, 0, 45, 8, 0, 0};

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.button_slot = '0;
    in_ch.event_kind  = '0;
    in_ch.time_ms     = '0;
    out_ch.ready      = 1'b0;
    in_took           = 1'b0;
    items_total       = 0;
    items_sent        = 0;
    live_events       = 0;
    chords_checked    = 0;
    mismatch_count    = 0;
    settings_used     = 1;
    quiet_cycles      = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_off_asked    = 0;
    hold_off_granted  = 0;
    hold_off_left     = 0;
    stamp_clock       = '0;
    hold_limit        = THR_RESET;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      held_down[i]   = 1'b0;
      press_stamp[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset threshold
    queue_event(4'd3, KIND_RELEASE, 32'd100);          // release with no press
    queue_event(4'd0, KIND_PRESS, 32'd0);
    queue_event(4'd1, KIND_PRESS, 32'd10);
    queue_event(4'd9, KIND_PRESS, 32'd20);             // top slot
    queue_event(4'd4, KIND_PRESS, 32'd400);
    queue_event(4'd4, KIND_RELEASE, 32'd500);          // tap under three holds
    queue_event(4'd2, KIND_REPEAT, 32'd500);
    queue_event(4'd2, KIND_UNKNOWN, 32'd500);
    queue_event(4'd10, KIND_PRESS, 32'd510);           // slots past the last button
    queue_event(4'd15, KIND_RELEASE, 32'd520);
    queue_event(4'd5, KIND_PRESS, 32'd1000);
    queue_event(4'd5, KIND_RELEASE, 32'd1250);         // held exactly the threshold
    queue_event(4'd2, KIND_PRESS, 32'd2000);
    queue_event(4'd3, KIND_PRESS, 32'd2100);
    queue_event(4'd3, KIND_RELEASE, 32'd2250);         // slot 2 down exactly the threshold
    queue_event(4'd2, KIND_RELEASE, 32'd1900);         // time going backward
    queue_event(4'd8, KIND_PRESS, 32'hFFFF_FFF0);
    queue_event(4'd8, KIND_RELEASE, 32'hFFFF_FFFF);    // largest time
    queue_event(4'd0, KIND_RELEASE, 32'hFFFF_FFFF);
    queue_event(4'd1, KIND_RELEASE, 32'hFFFF_FFFF);
    queue_event(4'd9, KIND_RELEASE, 32'd0);            // released after wrap, still down
    queue_event(4'd9, KIND_RELEASE, 32'd5);
    wait_drained();

    // random phases, one threshold and one idle pattern each
    for (int p = 0; p < N_PHASES; p++) begin
      thr = (phase_thr[p] < 0) ? $urandom_range(2, 4000) : phase_thr[p];
      write_threshold(THR_W'(thr));
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_stall[p];
      if (p == 1) hold_off_asked++;
      target = live_events + PHASE_EVENTS;
      while (live_events < target) begin
        if ($urandom_range(0, 4) == 0) queue_noise();
        else queue_chord_burst(thr);
      end
      wait_drained();
    end

    $display("Covered %0d button events and %0d chord items over %0d threshold settings,",
             items_sent, chords_checked, settings_used);
    $display("with gap-free, sender-gap, receiver-stall, mixed and long hold-off phases.");
    if (mismatch_count == 0) begin
      $display("button_chord_detector regression: pass");
    end else begin
      $display("button_chord_detector regression: fail");
    end
    $finish;
  end

endmodule
